>>> hdl/dfcd_pkg.sv
// Package for the display fetch contention delay block.
// Holds line geometry constants, register indexes, delay patterns and the divider step.
// Depends on nothing.
package dfcd_pkg;

	localparam int BORDER_LINES = 24;
	localparam int ACTIVE_LINES = 192;
	localparam int BORDER_COLS  = 4;

	// Register index port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_LN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BORDER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;

	// Contention modes.
	localparam logic [1:0] MODE_A = 2'd1;
	localparam logic [1:0] MODE_B = 2'd2;
	localparam logic [10:0] OFFSET_A = 11'd1;
	localparam logic [10:0] OFFSET_B = 11'd4;

	localparam logic [2:0] PAT_A [8] = '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd6};
	localparam logic [2:0] PAT_B [8] = '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6};

	// Field widths.
	localparam int TIME_W = 17;
	localparam int TPL_W  = 9;
	localparam int BYTE_W = 8;

	// The position dividend gets POS_BIAS line lengths added so it never goes negative.
	localparam int POS_BIAS = 4 * BORDER_COLS;

	// Divider geometry: 18 quotient bits, three per pipeline stage.
	localparam int DIV_W       = 18;
	localparam int DIV_STAGES  = 6;
	localparam int STEPS_STAGE = DIV_W / DIV_STAGES;

	typedef struct packed {
		logic             neg;   // access came before the first line
		logic [DIV_W-1:0] nd;    // line dividend, consumed from the top
		logic [DIV_W-1:0] nu;    // position dividend, consumed from the top
		logic [DIV_W-1:0] q;     // line quotient built so far
		logic [TPL_W-1:0] rd;    // partial remainder of the line dividend
		logic [TPL_W-1:0] ru;    // partial remainder of the position dividend
	} div_st_t;

	// One restoring division step on both dividends.
	function automatic div_st_t div_step(input div_st_t st, input logic [TPL_W-1:0] tpl);
		div_st_t       r;
		logic [TPL_W:0] td;
		logic [TPL_W:0] tu;
		logic          qb;
		r  = st;
		td = {st.rd, st.nd[DIV_W-1]};
		tu = {st.ru, st.nu[DIV_W-1]};
		qb = (td >= {1'b0, tpl});
		if (qb) begin
			td = td - {1'b0, tpl};
		end
		if (tu >= {1'b0, tpl}) begin
			tu = tu - {1'b0, tpl};
		end
		r.rd = td[TPL_W-1:0];
		r.ru = tu[TPL_W-1:0];
		r.q  = {st.q[DIV_W-2:0], qb};
		r.nd = {st.nd[DIV_W-2:0], 1'b0};
		r.nu = {st.nu[DIV_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

>>> hdl/display_fetch_contention_delay.sv
// Top level of the display fetch contention delay block.
// Depends on dfcd_pkg for constants, patterns and the divider step.

// Returns the wait ticks that the video fetch forces on a CPU access at a given
// tick of the frame. One transaction is taken every clock while the output is not
// held. The accepting clock registers the line and position dividends, the divider
// stages run a shared-shape restoring divider (three quotient bits per stage, both
// dividends side by side), and a last stage does the window test and the pattern
// lookup into the output register. A held output stalls the whole pipeline.
// Configuration writes are taken in every cycle and must only be made while no
// access is in flight.
module display_fetch_contention_delay (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dfcd_pkg::TIME_W-1:0]      access_time,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       wait_ticks,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dfcd_pkg::*;

	localparam int NS = DIV_STAGES + 1;

	logic [1:0]        pattern_mode_q;
	logic [TIME_W-1:0] first_line_time_q;
	logic [TPL_W-1:0]  ticks_per_line_q;
	logic [BYTE_W-1:0] left_border_q;
	logic [BYTE_W-1:0] screen_width_q;

	// Index k holds the register of pipeline stage k.
	logic    vld_s [1:NS];
	div_st_t pipe_s [1:NS];
	div_st_t next_s [2:NS];

	logic       adv;
	logic       out_valid_q;
	logic [2:0] wait_ticks_q;

	div_st_t          entry;
	logic [DIV_W:0]   diff;
	logic [DIV_W+1:0] usum;

	logic          in_lines;
	logic [10:0]   pos;
	logic [10:0]   off;
	logic [10:0]   lo;
	logic [10:0]   hi;
	logic          active;
	logic [2:0]    pat_val;
	logic [2:0]    wait_next;

	assign cfg_ready  = 1'b1;
	assign adv        = !out_valid_q || out_ready;
	assign in_ready   = adv;
	assign out_valid  = out_valid_q;
	assign wait_ticks = wait_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q    <= 2'd1;
			first_line_time_q <= 17'd8960;
			ticks_per_line_q  <= 9'd224;
			left_border_q     <= 8'd24;
			screen_width_q    <= 8'd128;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PATTERN_MODE: pattern_mode_q    <= cfg_data[1:0];
				CFG_FIRST_LINE:   first_line_time_q <= cfg_data;
				CFG_TICKS_PER_LN: ticks_per_line_q  <= cfg_data[TPL_W-1:0];
				CFG_LEFT_BORDER:  left_border_q     <= cfg_data[BYTE_W-1:0];
				CFG_SCREEN_WIDTH: screen_width_q    <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 dividends: d for the line, and d + left border - 4*BORDER_COLS with
	// POS_BIAS line lengths added for the position, which leaves its remainder unchanged.
	always_comb begin
		diff = {2'b00, access_time} - {2'b00, first_line_time_q};
		usum = {2'b00, diff[DIV_W-1:0]} + {{(DIV_W+2-BYTE_W){1'b0}}, left_border_q}
			+ (DIV_W+2)'({{(DIV_W+2-TPL_W){1'b0}}, ticks_per_line_q} * POS_BIAS)
			- (DIV_W+2)'(POS_BIAS);
		entry     = '0;
		entry.neg = diff[DIV_W];
		entry.nd  = diff[DIV_W-1:0];
		entry.nu  = usum[DIV_W-1:0];
	end

	always_comb begin
		for (int k = 2; k <= NS; k++) begin
			next_s[k] = pipe_s[k-1];
			for (int j = 0; j < STEPS_STAGE; j++) begin
				next_s[k] = div_step(next_s[k], ticks_per_line_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_valid_q <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[1] <= entry;
			for (int k = 2; k <= NS; k++) begin
				pipe_s[k] <= next_s[k];
			end
			wait_ticks_q <= wait_next;
		end
	end

	// Window test and pattern lookup on the finished quotient and remainder.
	always_comb begin
		in_lines = (pipe_s[NS].q >= DIV_W'(BORDER_LINES))
			&& (pipe_s[NS].q < DIV_W'(BORDER_LINES + ACTIVE_LINES));
		pos = {2'b00, pipe_s[NS].ru};
		off = (pattern_mode_q == MODE_A) ? OFFSET_A : OFFSET_B;
		lo  = {3'b000, left_border_q} - off;
		hi  = {3'b000, left_border_q} + {3'b000, screen_width_q} - off;
		active = ($signed(pos) >= $signed(lo)) && ($signed(pos) < $signed(hi));
		pat_val = (pattern_mode_q == MODE_A) ? PAT_A[pos[2:0]] : PAT_B[pos[2:0]];
		if ((pattern_mode_q != MODE_A && pattern_mode_q != MODE_B)
			|| ticks_per_line_q == '0 || pipe_s[NS].neg || !in_lines || !active) begin
			wait_next = 3'd0;
		end else begin
			wait_next = pat_val;
		end
	end

endmodule

>>> tb/display_fetch_contention_delay_tb.sv
// Testbench for display_fetch_contention_delay: drives access times and register writes,
// predicts every wait tick count and checks each result in order. Depends on dfcd_pkg.
module display_fetch_contention_delay_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfcd_pkg::*;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int MAX_TIME     = 131071;
	localparam int PHASE_ITEMS  = 92;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct {
		logic [TIME_W-1:0] access;
		logic [2:0]        waits;
	} pending_wait_t;

	// Predicts the wait ticks of each access and holds them until the block answers.
	class contention_scoreboard;
		logic [1:0]        mode;
		logic [TIME_W-1:0] flt;
		logic [TPL_W-1:0]  tpl;
		logic [BYTE_W-1:0] lb;
		logic [BYTE_W-1:0] sw;
		pending_wait_t     expected_waits[$];
		int                mismatches;

		function new();
			mode = MODE_A;
			flt = 17'd8960;
			tpl = 9'd224;
			lb = 8'd24;
			sw = 8'd128;
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PATTERN_MODE: mode = data[1:0];
				CFG_FIRST_LINE:   flt = data[TIME_W-1:0];
				CFG_TICKS_PER_LN: tpl = data[TPL_W-1:0];
				CFG_LEFT_BORDER:  lb = data[BYTE_W-1:0];
				CFG_SCREEN_WIDTH: sw = data[BYTE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [2:0] predict_wait(logic [TIME_W-1:0] t);
			int off;
			int d;
			int line;
			int pos;
			int lbi;
			if (mode == MODE_A) begin
				off = int'(OFFSET_A);
			end else if (mode == MODE_B) begin
				off = int'(OFFSET_B);
			end else begin
				return 3'd0;
			end
			if (tpl == 0) begin
				return 3'd0;
			end
			d = int'(t) - int'(flt);
			if (d < 0) begin
				return 3'd0;
			end
			line = d / int'(tpl);
			if (line < BORDER_LINES || line >= BORDER_LINES + ACTIVE_LINES) begin
				return 3'd0;
			end
			lbi = int'(lb);
			// Truncating remainder, folded back into 0..tpl-1.
			pos = (d + lbi - 4 * BORDER_COLS) % int'(tpl);
			if (pos < 0) begin
				pos += int'(tpl);
			end
			if (pos < lbi - off || pos >= lbi + int'(sw) - off) begin
				return 3'd0;
			end
			return (mode == MODE_B) ? PAT_B[pos & 7] : PAT_A[pos & 7];
		endfunction

		function void note_access(logic [TIME_W-1:0] t);
			pending_wait_t p;
			p.access = t;
			p.waits = predict_wait(t);
			expected_waits.push_back(p);
		endfunction

		task check_wait(logic [2:0] got);
			pending_wait_t p;
			if (expected_waits.size() == 0) begin
				report_mismatch($sformatf("wait_ticks %0d with no access outstanding", got));
			end else begin
				p = expected_waits.pop_front();
				if (got !== p.waits) begin
					report_mismatch($sformatf("access_time %0d: wait_ticks %0d, expected %0d",
						p.access, got, p.waits));
				end
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [TIME_W-1:0]     access_time;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            wait_ticks;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	contention_scoreboard sb = new();
	int idle_pct = 10;
	int cycles = 0;

	display_fetch_contention_delay u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.access_time (access_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.wait_ticks  (wait_ticks),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Every transaction on the three channels is seen here, at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				sb.note_access(access_time);
			end
			if (out_valid && out_ready) begin
				sb.check_wait(wait_ticks);
			end
		end
	end

	task automatic send_access(input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		access_time <= t;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	// Half the writes to narrow fields carry random upper bits the block must drop.
	function automatic logic [CFG_DATA_W-1:0] cfg_word(input int value, input int width);
		logic [CFG_DATA_W-1:0] w;
		w = CFG_DATA_W'(value);
		if (width < CFG_DATA_W && $urandom_range(1) == 1) begin
			w = w | CFG_DATA_W'($urandom() << width);
		end
		return w;
	endfunction

	task automatic configure(input int mode, input int flt, input int tpl, input int lb,
			input int sw);
		write_reg(CFG_PATTERN_MODE, cfg_word(mode, 2));
		write_reg(CFG_FIRST_LINE, cfg_word(flt, TIME_W));
		write_reg(CFG_TICKS_PER_LN, cfg_word(tpl, TPL_W));
		write_reg(CFG_LEFT_BORDER, cfg_word(lb, BYTE_W));
		write_reg(CFG_SCREEN_WIDTH, cfg_word(sw, BYTE_W));
		write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
			CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// Stops sending, then waits for every outstanding result and a little more.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_waits.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Most accesses land in the active lines so that the window and pattern get exercised.
	function automatic logic [TIME_W-1:0] pick_access();
		int base;
		int span;
		int t;
		int sel;
		sel = $urandom_range(9);
		if (sel < 3 || sb.tpl == 0) begin
			return TIME_W'($urandom());
		end
		base = int'(sb.flt) + BORDER_LINES * int'(sb.tpl);
		span = ACTIVE_LINES * int'(sb.tpl);
		if (sel == 3) begin
			t = base - 1 + $urandom_range(1);
		end else if (sel == 4) begin
			t = base + span - 1 + $urandom_range(1);
		end else begin
			t = base + $urandom_range(span - 1);
		end
		return TIME_W'(t);
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_access(pick_access());
	endtask

	task automatic random_setting();
		int tpl;
		int room;
		tpl = ($urandom_range(3) == 0) ? $urandom_range(8, 1) : $urandom_range(511, 9);
		room = MAX_TIME - (BORDER_LINES + ACTIVE_LINES) * tpl;
		if (room < 0) begin
			room = 0;
		end
		configure(($urandom_range(1) == 1) ? MODE_B : MODE_A, $urandom_range(room), tpl,
			$urandom_range(255), $urandom_range(255));
	endtask

	initial begin
		int directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		access_time = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings after reset: frame ends, first line, active line edges, every
		// pattern entry, and the first and last position of the fetch window.
		directed = '{0, MAX_TIME, 8959, 8960, 14335, 14336, 14350, 14351, 14352, 14353,
			14354, 14355, 14356, 14357, 14358, 14478, 14479, 14580, 57343, 57344};
		foreach (directed[i]) begin
			send_access(TIME_W'(directed[i]));
		end
		run_random(PHASE_ITEMS);

		for (int phase = 1; phase <= 11; phase++) begin
			drain();
			idle_pct = (phase == 8) ? 0 : 10;
			case (phase)
				1:  configure(MODE_B, 8960, 224, 24, 128);
				2:  configure(MODE_A, 0, 1, 0, 0);
				3:  configure(MODE_B, MAX_TIME, 511, 255, 255);
				// The unused mode code must behave as no contention.
				4:  configure(MODE_UNUSED, 0, 224, 24, 128);
				// A zero line length must give no contention.
				5:  configure(MODE_A, 0, 0, 24, 128);
				6:  configure(MODE_NONE, 8960, 224, 24, 128);
				7:  configure(MODE_A, 0, 8, 255, 255);
				default: random_setting();
			endcase
			run_random(PHASE_ITEMS);
		end

		drain();
		if (sb.expected_waits.size() != 0) begin
			sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_waits.size()));
		end
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
